// ===== src/gsr_pkg.sv =====
// ----------------------------------------------------------------------------
// gsr_pkg
// shared types, constants and response tables of the controller responder
// ----------------------------------------------------------------------------
`default_nettype none

package gsr_pkg;

  // response table geometry
  localparam int TableDepth = 32;
  localparam int Entries    = 6;
  localparam int TblCount   = 12;
  localparam int CountMax   = 63;

  // fixed reply bytes
  localparam logic [7:0] HeaderByte  = 8'hff;
  localparam logic [7:0] AckByte     = 8'h5a;
  localparam logic [7:0] ModeDigital = 8'h41;
  localparam logic [7:0] ModeEscape  = 8'hf3;
  localparam logic [7:0] ModeAnalog  = 8'h71;

  // host commands
  localparam logic [7:0] CmdCheck  = 8'h41;
  localparam logic [7:0] CmdEscape = 8'h43;
  localparam logic [7:0] CmdSetMod = 8'h44;
  localparam logic [7:0] CmdModel  = 8'h45;
  localparam logic [7:0] CmdQueryA = 8'h46;
  localparam logic [7:0] CmdQuery7 = 8'h47;
  localparam logic [7:0] CmdQueryB = 8'h4c;
  localparam logic [7:0] CmdMotor  = 8'h4d;

  // table select codes
  localparam logic [3:0] TblPoll  = 4'd0;
  localparam logic [3:0] TblCheck = 4'd1;
  localparam logic [3:0] TblEscA  = 4'd2;
  localparam logic [3:0] TblEscB  = 4'd3;
  localparam logic [3:0] Tbl44    = 4'd4;
  localparam logic [3:0] TblModel = 4'd5;
  localparam logic [3:0] Tbl46A   = 4'd6;
  localparam logic [3:0] Tbl46B   = 4'd7;
  localparam logic [3:0] Tbl47    = 4'd8;
  localparam logic [3:0] Tbl4CA   = 4'd9;
  localparam logic [3:0] Tbl4CB   = 4'd10;
  localparam logic [3:0] TblMotor = 4'd11;

  localparam logic [7:0] Tables [TblCount][Entries] = '{
    '{8'hbf, 8'hbf, 8'hf7, 8'hf7, 8'hf7, 8'hf7},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h02, 8'h02, 8'h00, 8'h02, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h0a},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h14},
    '{8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h04, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h06, 8'h00, 8'h00},
    '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff}
  };

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } rx_item_t;

  typedef struct packed {
    logic [7:0] next_byte;
    logic       frame_done;
  } tx_item_t;

  typedef struct packed {
    logic [7:0] mode_id;
    logic       toggle_query_a;
    logic       toggle_query_b;
    logic [5:0] byte_count;
    logic [5:0] table_position;
    logic [3:0] table_select;
  } gsr_state_t;

  // table entry, zero for an unknown table or past the defined entries or the table depth
  function automatic logic [7:0] table_entry(input logic [3:0] sel, input logic [5:0] pos);
    logic [7:0] v;
    v = 8'h00;
    if ((sel < 4'(TblCount)) && (pos < 6'(Entries)) && ({1'b0, pos} < 7'(TableDepth))) begin
      v = Tables[sel][pos[2:0]];
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== src/gsr_rx_if.sv =====
// ----------------------------------------------------------------------------
// gsr_rx_if
// valid/ready channel carrying one received byte and its frame-end flag
// ----------------------------------------------------------------------------
`default_nettype none

interface gsr_rx_if;
  logic             valid;
  logic             ready;
  gsr_pkg::rx_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/gsr_tx_if.sv =====
// ----------------------------------------------------------------------------
// gsr_tx_if
// valid/ready channel carrying the byte to load for the next transfer
// ----------------------------------------------------------------------------
`default_nettype none

interface gsr_tx_if;
  logic             valid;
  logic             ready;
  gsr_pkg::tx_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/gsr_step.sv =====
// ----------------------------------------------------------------------------
// gsr_step
// per-byte protocol step: command decode, table lookup and state update
// ----------------------------------------------------------------------------
`default_nettype none

module gsr_step (
  input  gsr_pkg::gsr_state_t state,
  input  gsr_pkg::rx_item_t   item,
  output gsr_pkg::gsr_state_t state_next,
  output gsr_pkg::tx_item_t   result
);
  import gsr_pkg::*;

  logic [5:0] count_inc;
  gsr_state_t picked;
  logic [7:0] reply;

  assign count_inc = (state.byte_count < 6'(CountMax)) ? state.byte_count + 6'd1
                                                       : state.byte_count;

  // table choice on the command byte
  always_comb begin
    picked            = state;
    picked.byte_count = count_inc;
    if (count_inc == 6'd2) begin
      case (item.rx_byte)
        CmdCheck:  picked.table_select = TblCheck;
        CmdEscape: begin
          if (state.mode_id == ModeDigital) begin
            picked.mode_id      = ModeEscape;
            picked.table_select = TblEscB;
          end else begin
            picked.mode_id      = ModeDigital;
            picked.table_select = TblEscA;
          end
        end
        CmdSetMod: begin
          picked.mode_id      = ModeAnalog;
          picked.table_select = Tbl44;
        end
        CmdModel:  picked.table_select = TblModel;
        CmdQueryA: begin
          picked.table_select   = state.toggle_query_a ? Tbl46B : Tbl46A;
          picked.toggle_query_a = ~state.toggle_query_a;
        end
        CmdQuery7: picked.table_select = Tbl47;
        CmdQueryB: begin
          picked.table_select   = state.toggle_query_b ? Tbl4CB : Tbl4CA;
          picked.toggle_query_b = ~state.toggle_query_b;
        end
        CmdMotor:  picked.table_select = TblMotor;
        default:   picked.table_select = TblPoll;
      endcase
    end
  end

  always_comb begin
    state_next = picked;
    if (count_inc == 6'd1) begin
      reply = state.mode_id;
    end else if (count_inc == 6'd2) begin
      reply = AckByte;
    end else begin
      reply = table_entry(picked.table_select, picked.table_position);
      if (picked.table_position < 6'(CountMax)) begin
        state_next.table_position = picked.table_position + 6'd1;
      end
    end
    // frame end rewinds the counters and preloads the header
    if (item.frame_end) begin
      state_next.byte_count     = '0;
      state_next.table_position = '0;
      reply                     = HeaderByte;
    end
    result.next_byte  = reply;
    result.frame_done = item.frame_end;
  end

endmodule

`default_nettype wire

// ===== src/gamepad_spi_slave_responder.sv =====
// ----------------------------------------------------------------------------
// gamepad_spi_slave_responder
// slave-side game-controller reply generator, one item per byte transfer
// ----------------------------------------------------------------------------
// usage
//   rx carries each byte received from the host and a flag that marks the
//   byte after which select went high. tx returns, for every rx item, the
//   byte to load into the shift register for the next transfer and a flag
//   that the frame was closed (then the byte is always the 0xff header).
//   a frame answers with the mode id, 0x5a, then entries of the response
//   table picked by the frame's second byte; the table stays selected
//   across frames until another command arrives.
// timing
//   two register stages: an input register and a result register, with the
//   decode, table lookup and state update between them. tx.valid rises once
//   an item has moved from the input register into the result register,
//   where it waits to be taken; one item per cycle is sustained while tx is ready.
// reset
//   synchronous rst empties both stages and returns the mode id to the
//   digital id, the toggles and counters to zero and the poll table.
// stalls
//   while tx is held off the result waits in its register; rx stays ready
//   until the input register is also occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module gamepad_spi_slave_responder (
  input  wire        clk,
  input  wire        rst,
  gsr_rx_if.sink     rx,
  gsr_tx_if.source   tx
);
  import gsr_pkg::*;

  // input stage
  logic     in_valid;
  rx_item_t in_item;

  // protocol state
  gsr_state_t state;
  gsr_state_t state_next;
  tx_item_t   result;

  // result stage
  logic     out_valid;
  tx_item_t out_item;

  logic advance;

  // the input item moves on when the result register is free or draining
  assign advance  = in_valid && (!out_valid || tx.ready);
  assign rx.ready = !in_valid || advance;

  assign tx.valid = out_valid;
  assign tx.data  = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_item <= rx.data;
    end
  end

  gsr_step u_step (
    .state      (state),
    .item       (in_item),
    .state_next (state_next),
    .result     (result)
  );

  // state only moves when an item is committed to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode_id        <= ModeDigital;
      state.toggle_query_a <= 1'b0;
      state.toggle_query_b <= 1'b0;
      state.byte_count     <= '0;
      state.table_position <= '0;
      state.table_select   <= TblPoll;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

  // a closed frame always preloads the header
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.frame_done |-> out_item.next_byte == HeaderByte)
    else $error("frame close without header byte");

  // the table position never runs ahead of the byte count
  assert property (@(posedge clk) disable iff (rst)
    state.table_position <= state.byte_count)
    else $error("table position ahead of byte count");

  // only the three known mode ids can be reached
  assert property (@(posedge clk) disable iff (rst)
    state.mode_id == ModeDigital || state.mode_id == ModeEscape ||
    state.mode_id == ModeAnalog)
    else $error("mode id left its known values");

  // with both stages full and tx stalled, no new item may enter
  assert property (@(posedge clk) disable iff (rst)
    in_valid && out_valid && !tx.ready |-> !rx.ready)
    else $error("input taken while pipeline is full");

endmodule

`default_nettype wire
